// ----- rtl/sbc_pkg.sv -----
// Shared constants, types and the jet RGB565 colour table for the spectrum
// bin to colour map pipeline. No dependencies.
package sbc_pkg;

    localparam int DATA_W     = 16;
    localparam int DB_W       = 8;
    localparam int LOG_W      = 21;   // Q5.16 base-2 logarithm of the power
    localparam int FRAC_W     = 16;
    localparam int INT_W      = 5;
    localparam int SQ_STAGES  = FRAC_W;
    localparam int IDX_W      = 10;   // index into the 1024-entry map
    localparam int DIV_STAGES = IDX_W;
    localparam int NUM_W      = 48;   // numerator when it is known to lie below den
    localparam int DIVD_W     = 60;   // 2046*num + den
    localparam int DSR_W      = 49;   // 2*den

    localparam int FFT_SIZE   = 512;
    localparam int LUT_SIZE   = 1024;
    localparam logic [IDX_W-1:0] LUT_TOP = IDX_W'(LUT_SIZE - 1);

    // 2*log2(FFT_SIZE) in Q.16: the magnitude is divided by the transform size.
    localparam logic signed [21:0] LOG_OFFSET = 22'(2 * $clog2(FFT_SIZE) * 65536);
    // 10*log10(2) in Q.24.
    localparam logic signed [26:0] TEN_LOG10_2_Q24 = 27'sd50504453;

    localparam logic signed [DB_W-1:0] MIN_DB_RST = -8'sd50;
    localparam logic signed [DB_W-1:0] MAX_DB_RST = 8'sd50;

    localparam logic CFG_MIN_DB = 1'b0;
    localparam logic CFG_MAX_DB = 1'b1;

    // How the final index is chosen once the comparisons are done.
    typedef struct packed {
        logic force_low;   // index 0
        logic force_high;  // index LUT_TOP
    } t_cls;

    localparam logic [15:0] JET565 [1024] = '{
        16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'h0010,
        16'h0011, 16'h0011, 16'h0011, 16'h0011, 16'h0011, 16'h0011, 16'h0011, 16'h0011,
        16'h0012, 16'h0012, 16'h0012, 16'h0012, 16'h0012, 16'h0012, 16'h0012, 16'h0012,
        16'h0013, 16'h0013, 16'h0013, 16'h0013, 16'h0013, 16'h0013, 16'h0013, 16'h0013,
        16'h0013, 16'h0014, 16'h0014, 16'h0014, 16'h0014, 16'h0014, 16'h0014, 16'h0014,
        16'h0014, 16'h0015, 16'h0015, 16'h0015, 16'h0015, 16'h0015, 16'h0015, 16'h0015,
        16'h0015, 16'h0016, 16'h0016, 16'h0016, 16'h0016, 16'h0016, 16'h0016, 16'h0016,
        16'h0016, 16'h0017, 16'h0017, 16'h0017, 16'h0017, 16'h0017, 16'h0017, 16'h0017,
        16'h0017, 16'h0017, 16'h0018, 16'h0018, 16'h0018, 16'h0018, 16'h0018, 16'h0018,
        16'h0018, 16'h0018, 16'h0019, 16'h0019, 16'h0019, 16'h0019, 16'h0019, 16'h0019,
        16'h0019, 16'h0019, 16'h001A, 16'h001A, 16'h001A, 16'h001A, 16'h001A, 16'h001A,
        16'h001A, 16'h001A, 16'h001B, 16'h001B, 16'h001B, 16'h001B, 16'h001B, 16'h001B,
        16'h001B, 16'h001B, 16'h001B, 16'h001C, 16'h001C, 16'h001C, 16'h001C, 16'h001C,
        16'h001C, 16'h001C, 16'h001C, 16'h001D, 16'h001D, 16'h001D, 16'h001D, 16'h001D,
        16'h001D, 16'h001D, 16'h001D, 16'h001E, 16'h001E, 16'h001E, 16'h001E, 16'h001E,
        16'h001E, 16'h001E, 16'h001E, 16'h001F, 16'h001F, 16'h001F, 16'h001F, 16'h001F,
        16'h001F, 16'h001F, 16'h003F, 16'h003F, 16'h003F, 16'h003F, 16'h005F, 16'h005F,
        16'h005F, 16'h005F, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h009F, 16'h009F,
        16'h009F, 16'h009F, 16'h00BF, 16'h00BF, 16'h00BF, 16'h00BF, 16'h00DF, 16'h00DF,
        16'h00DF, 16'h00DF, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 16'h011F, 16'h011F,
        16'h011F, 16'h011F, 16'h013F, 16'h013F, 16'h013F, 16'h013F, 16'h015F, 16'h015F,
        16'h015F, 16'h015F, 16'h017F, 16'h017F, 16'h017F, 16'h017F, 16'h019F, 16'h019F,
        16'h019F, 16'h019F, 16'h01BF, 16'h01BF, 16'h01BF, 16'h01BF, 16'h01DF, 16'h01DF,
        16'h01DF, 16'h01DF, 16'h01FF, 16'h01FF, 16'h01FF, 16'h01FF, 16'h021F, 16'h021F,
        16'h021F, 16'h021F, 16'h021F, 16'h023F, 16'h023F, 16'h023F, 16'h023F, 16'h025F,
        16'h025F, 16'h025F, 16'h025F, 16'h027F, 16'h027F, 16'h027F, 16'h027F, 16'h029F,
        16'h029F, 16'h029F, 16'h029F, 16'h02BF, 16'h02BF, 16'h02BF, 16'h02BF, 16'h02DF,
        16'h02DF, 16'h02DF, 16'h02DF, 16'h02FF, 16'h02FF, 16'h02FF, 16'h02FF, 16'h031F,
        16'h031F, 16'h031F, 16'h031F, 16'h033F, 16'h033F, 16'h033F, 16'h033F, 16'h035F,
        16'h035F, 16'h035F, 16'h035F, 16'h037F, 16'h037F, 16'h037F, 16'h037F, 16'h039F,
        16'h039F, 16'h039F, 16'h039F, 16'h03BF, 16'h03BF, 16'h03BF, 16'h03BF, 16'h03DF,
        16'h03DF, 16'h03DF, 16'h03DF, 16'h03FF, 16'h03FF, 16'h03FF, 16'h03FF, 16'h041F,
        16'h041F, 16'h041F, 16'h041F, 16'h041F, 16'h043F, 16'h043F, 16'h043F, 16'h043F,
        16'h045F, 16'h045F, 16'h045F, 16'h045F, 16'h047F, 16'h047F, 16'h047F, 16'h047F,
        16'h049F, 16'h049F, 16'h049F, 16'h049F, 16'h04BF, 16'h04BF, 16'h04BF, 16'h04BF,
        16'h04DF, 16'h04DF, 16'h04DF, 16'h04DF, 16'h04FF, 16'h04FF, 16'h04FF, 16'h04FF,
        16'h051F, 16'h051F, 16'h051F, 16'h051F, 16'h053F, 16'h053F, 16'h053F, 16'h053F,
        16'h055F, 16'h055F, 16'h055F, 16'h055F, 16'h057F, 16'h057F, 16'h057F, 16'h057F,
        16'h059F, 16'h059F, 16'h059F, 16'h059F, 16'h05BF, 16'h05BF, 16'h05BF, 16'h05BF,
        16'h05DF, 16'h05DF, 16'h05DF, 16'h05DF, 16'h05FF, 16'h05FF, 16'h05FF, 16'h05FF,
        16'h05FF, 16'h061F, 16'h061F, 16'h061F, 16'h061F, 16'h063F, 16'h063F, 16'h063F,
        16'h063F, 16'h065F, 16'h065F, 16'h065F, 16'h065F, 16'h067F, 16'h067F, 16'h067F,
        16'h067F, 16'h069F, 16'h069F, 16'h069F, 16'h069F, 16'h06BF, 16'h06BF, 16'h06BF,
        16'h06BF, 16'h06DF, 16'h06DF, 16'h06DF, 16'h06DF, 16'h06FF, 16'h06FF, 16'h06FF,
        16'h06FF, 16'h071F, 16'h071F, 16'h071F, 16'h071F, 16'h073F, 16'h073F, 16'h073F,
        16'h073F, 16'h075F, 16'h075F, 16'h075F, 16'h075F, 16'h077F, 16'h077F, 16'h077F,
        16'h077F, 16'h079F, 16'h079F, 16'h079F, 16'h079F, 16'h07BF, 16'h07BF, 16'h07BF,
        16'h07BF, 16'h07DF, 16'h07DF, 16'h07DF, 16'h07DF, 16'h07FF, 16'h07FF, 16'h07FF,
        16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h0FFE, 16'h0FFE, 16'h0FFE, 16'h0FFE,
        16'h0FFE, 16'h0FFE, 16'h0FFE, 16'h0FFE, 16'h17FD, 16'h17FD, 16'h17FD, 16'h17FD,
        16'h17FD, 16'h17FD, 16'h17FD, 16'h17FD, 16'h1FFC, 16'h1FFC, 16'h1FFC, 16'h1FFC,
        16'h1FFC, 16'h1FFC, 16'h1FFC, 16'h1FFC, 16'h27FB, 16'h27FB, 16'h27FB, 16'h27FB,
        16'h27FB, 16'h27FB, 16'h27FB, 16'h27FB, 16'h27FB, 16'h2FFA, 16'h2FFA, 16'h2FFA,
        16'h2FFA, 16'h2FFA, 16'h2FFA, 16'h2FFA, 16'h2FFA, 16'h37F9, 16'h37F9, 16'h37F9,
        16'h37F9, 16'h37F9, 16'h37F9, 16'h37F9, 16'h37F9, 16'h3FF8, 16'h3FF8, 16'h3FF8,
        16'h3FF8, 16'h3FF8, 16'h3FF8, 16'h3FF8, 16'h3FF8, 16'h47F7, 16'h47F7, 16'h47F7,
        16'h47F7, 16'h47F7, 16'h47F7, 16'h47F7, 16'h47F7, 16'h47F7, 16'h4FF6, 16'h4FF6,
        16'h4FF6, 16'h4FF6, 16'h4FF6, 16'h4FF6, 16'h4FF6, 16'h4FF6, 16'h57F5, 16'h57F5,
        16'h57F5, 16'h57F5, 16'h57F5, 16'h57F5, 16'h57F5, 16'h57F5, 16'h5FF4, 16'h5FF4,
        16'h5FF4, 16'h5FF4, 16'h5FF4, 16'h5FF4, 16'h5FF4, 16'h5FF4, 16'h67F3, 16'h67F3,
        16'h67F3, 16'h67F3, 16'h67F3, 16'h67F3, 16'h67F3, 16'h67F3, 16'h67F3, 16'h6FF2,
        16'h6FF2, 16'h6FF2, 16'h6FF2, 16'h6FF2, 16'h6FF2, 16'h6FF2, 16'h6FF2, 16'h77F1,
        16'h77F1, 16'h77F1, 16'h77F1, 16'h77F1, 16'h77F1, 16'h77F1, 16'h77F1, 16'h7FF0,
        16'h7FF0, 16'h7FF0, 16'h7FF0, 16'h7FF0, 16'h7FF0, 16'h7FF0, 16'h7FF0, 16'h87F0,
        16'h87EF, 16'h87EF, 16'h87EF, 16'h87EF, 16'h87EF, 16'h87EF, 16'h87EF, 16'h87EF,
        16'h8FEE, 16'h8FEE, 16'h8FEE, 16'h8FEE, 16'h8FEE, 16'h8FEE, 16'h8FEE, 16'h8FEE,
        16'h97ED, 16'h97ED, 16'h97ED, 16'h97ED, 16'h97ED, 16'h97ED, 16'h97ED, 16'h97ED,
        16'h9FEC, 16'h9FEC, 16'h9FEC, 16'h9FEC, 16'h9FEC, 16'h9FEC, 16'h9FEC, 16'h9FEC,
        16'h9FEC, 16'hA7EB, 16'hA7EB, 16'hA7EB, 16'hA7EB, 16'hA7EB, 16'hA7EB, 16'hA7EB,
        16'hA7EB, 16'hAFEA, 16'hAFEA, 16'hAFEA, 16'hAFEA, 16'hAFEA, 16'hAFEA, 16'hAFEA,
        16'hAFEA, 16'hB7E9, 16'hB7E9, 16'hB7E9, 16'hB7E9, 16'hB7E9, 16'hB7E9, 16'hB7E9,
        16'hB7E9, 16'hBFE8, 16'hBFE8, 16'hBFE8, 16'hBFE8, 16'hBFE8, 16'hBFE8, 16'hBFE8,
        16'hBFE8, 16'hBFE8, 16'hC7E7, 16'hC7E7, 16'hC7E7, 16'hC7E7, 16'hC7E7, 16'hC7E7,
        16'hC7E7, 16'hC7E7, 16'hCFE6, 16'hCFE6, 16'hCFE6, 16'hCFE6, 16'hCFE6, 16'hCFE6,
        16'hCFE6, 16'hCFE6, 16'hD7E5, 16'hD7E5, 16'hD7E5, 16'hD7E5, 16'hD7E5, 16'hD7E5,
        16'hD7E5, 16'hD7E5, 16'hDFE4, 16'hDFE4, 16'hDFE4, 16'hDFE4, 16'hDFE4, 16'hDFE4,
        16'hDFE4, 16'hDFE4, 16'hDFE4, 16'hE7E3, 16'hE7E3, 16'hE7E3, 16'hE7E3, 16'hE7E3,
        16'hE7E3, 16'hE7E3, 16'hE7E3, 16'hEFE2, 16'hEFE2, 16'hEFE2, 16'hEFE2, 16'hEFE2,
        16'hEFE2, 16'hEFE2, 16'hEFE2, 16'hF7E1, 16'hF7E1, 16'hF7E1, 16'hF7E1, 16'hF7E1,
        16'hF7E1, 16'hF7E1, 16'hF7E1, 16'hFFE0, 16'hFFE0, 16'hFFE0, 16'hFFE0, 16'hFFE0,
        16'hFFE0, 16'hFFE0, 16'hFFC0, 16'hFFC0, 16'hFFC0, 16'hFFC0, 16'hFFA0, 16'hFFA0,
        16'hFFA0, 16'hFFA0, 16'hFF80, 16'hFF80, 16'hFF80, 16'hFF80, 16'hFF60, 16'hFF60,
        16'hFF60, 16'hFF60, 16'hFF40, 16'hFF40, 16'hFF40, 16'hFF40, 16'hFF20, 16'hFF20,
        16'hFF20, 16'hFF20, 16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00, 16'hFEE0, 16'hFEE0,
        16'hFEE0, 16'hFEE0, 16'hFEC0, 16'hFEC0, 16'hFEC0, 16'hFEC0, 16'hFEA0, 16'hFEA0,
        16'hFEA0, 16'hFEA0, 16'hFE80, 16'hFE80, 16'hFE80, 16'hFE80, 16'hFE60, 16'hFE60,
        16'hFE60, 16'hFE60, 16'hFE40, 16'hFE40, 16'hFE40, 16'hFE40, 16'hFE20, 16'hFE20,
        16'hFE20, 16'hFE20, 16'hFE00, 16'hFE00, 16'hFE00, 16'hFE00, 16'hFDE0, 16'hFDE0,
        16'hFDE0, 16'hFDE0, 16'hFDE0, 16'hFDC0, 16'hFDC0, 16'hFDC0, 16'hFDC0, 16'hFDA0,
        16'hFDA0, 16'hFDA0, 16'hFDA0, 16'hFD80, 16'hFD80, 16'hFD80, 16'hFD80, 16'hFD60,
        16'hFD60, 16'hFD60, 16'hFD60, 16'hFD40, 16'hFD40, 16'hFD40, 16'hFD40, 16'hFD20,
        16'hFD20, 16'hFD20, 16'hFD20, 16'hFD00, 16'hFD00, 16'hFD00, 16'hFD00, 16'hFCE0,
        16'hFCE0, 16'hFCE0, 16'hFCE0, 16'hFCC0, 16'hFCC0, 16'hFCC0, 16'hFCC0, 16'hFCA0,
        16'hFCA0, 16'hFCA0, 16'hFCA0, 16'hFC80, 16'hFC80, 16'hFC80, 16'hFC80, 16'hFC60,
        16'hFC60, 16'hFC60, 16'hFC60, 16'hFC40, 16'hFC40, 16'hFC40, 16'hFC40, 16'hFC20,
        16'hFC20, 16'hFC20, 16'hFC20, 16'hFC00, 16'hFC00, 16'hFC00, 16'hFC00, 16'hFC00,
        16'hFBE0, 16'hFBE0, 16'hFBE0, 16'hFBE0, 16'hFBC0, 16'hFBC0, 16'hFBC0, 16'hFBC0,
        16'hFBA0, 16'hFBA0, 16'hFBA0, 16'hFBA0, 16'hFB80, 16'hFB80, 16'hFB80, 16'hFB80,
        16'hFB60, 16'hFB60, 16'hFB60, 16'hFB60, 16'hFB40, 16'hFB40, 16'hFB40, 16'hFB40,
        16'hFB20, 16'hFB20, 16'hFB20, 16'hFB20, 16'hFB00, 16'hFB00, 16'hFB00, 16'hFB00,
        16'hFAE0, 16'hFAE0, 16'hFAE0, 16'hFAE0, 16'hFAC0, 16'hFAC0, 16'hFAC0, 16'hFAC0,
        16'hFAA0, 16'hFAA0, 16'hFAA0, 16'hFAA0, 16'hFA80, 16'hFA80, 16'hFA80, 16'hFA80,
        16'hFA60, 16'hFA60, 16'hFA60, 16'hFA60, 16'hFA40, 16'hFA40, 16'hFA40, 16'hFA40,
        16'hFA20, 16'hFA20, 16'hFA20, 16'hFA20, 16'hFA00, 16'hFA00, 16'hFA00, 16'hFA00,
        16'hFA00, 16'hF9E0, 16'hF9E0, 16'hF9E0, 16'hF9E0, 16'hF9C0, 16'hF9C0, 16'hF9C0,
        16'hF9C0, 16'hF9A0, 16'hF9A0, 16'hF9A0, 16'hF9A0, 16'hF980, 16'hF980, 16'hF980,
        16'hF980, 16'hF960, 16'hF960, 16'hF960, 16'hF960, 16'hF940, 16'hF940, 16'hF940,
        16'hF940, 16'hF920, 16'hF920, 16'hF920, 16'hF920, 16'hF900, 16'hF900, 16'hF900,
        16'hF900, 16'hF8E0, 16'hF8E0, 16'hF8E0, 16'hF8E0, 16'hF8C0, 16'hF8C0, 16'hF8C0,
        16'hF8C0, 16'hF8A0, 16'hF8A0, 16'hF8A0, 16'hF8A0, 16'hF880, 16'hF880, 16'hF880,
        16'hF880, 16'hF860, 16'hF860, 16'hF860, 16'hF860, 16'hF840, 16'hF840, 16'hF840,
        16'hF840, 16'hF820, 16'hF820, 16'hF820, 16'hF820, 16'hF800, 16'hF800, 16'hF800,
        16'hF800, 16'hF800, 16'hF800, 16'hF800, 16'hF000, 16'hF000, 16'hF000, 16'hF000,
        16'hF000, 16'hF000, 16'hF000, 16'hF000, 16'hE800, 16'hE800, 16'hE800, 16'hE800,
        16'hE800, 16'hE800, 16'hE800, 16'hE800, 16'hE000, 16'hE000, 16'hE000, 16'hE000,
        16'hE000, 16'hE000, 16'hE000, 16'hE000, 16'hD800, 16'hD800, 16'hD800, 16'hD800,
        16'hD800, 16'hD800, 16'hD800, 16'hD800, 16'hD800, 16'hD000, 16'hD000, 16'hD000,
        16'hD000, 16'hD000, 16'hD000, 16'hD000, 16'hD000, 16'hC800, 16'hC800, 16'hC800,
        16'hC800, 16'hC800, 16'hC800, 16'hC800, 16'hC800, 16'hC000, 16'hC000, 16'hC000,
        16'hC000, 16'hC000, 16'hC000, 16'hC000, 16'hC000, 16'hB800, 16'hB800, 16'hB800,
        16'hB800, 16'hB800, 16'hB800, 16'hB800, 16'hB800, 16'hB800, 16'hB000, 16'hB000,
        16'hB000, 16'hB000, 16'hB000, 16'hB000, 16'hB000, 16'hB000, 16'hA800, 16'hA800,
        16'hA800, 16'hA800, 16'hA800, 16'hA800, 16'hA800, 16'hA800, 16'hA000, 16'hA000,
        16'hA000, 16'hA000, 16'hA000, 16'hA000, 16'hA000, 16'hA000, 16'h9800, 16'h9800,
        16'h9800, 16'h9800, 16'h9800, 16'h9800, 16'h9800, 16'h9800, 16'h9800, 16'h9000,
        16'h9000, 16'h9000, 16'h9000, 16'h9000, 16'h9000, 16'h9000, 16'h9000, 16'h8800,
        16'h8800, 16'h8800, 16'h8800, 16'h8800, 16'h8800, 16'h8800, 16'h8800, 16'h8000,
        16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000
    };

endpackage

// ----- rtl/sbc_log2.sv -----
// Power and base-2 logarithm pipeline: squares the bin, normalises the power
// and takes one fraction bit per squaring stage. Depends on sbc_pkg.
module sbc_log2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_vld,
    input  logic signed [15:0]            i_re,
    input  logic signed [15:0]            i_im,
    output logic                          o_vld,
    output logic [sbc_pkg::LOG_W-1:0]     o_log,
    output logic                          o_zero
);

    localparam int N = sbc_pkg::SQ_STAGES;

    logic signed [31:0] w_re2;
    logic signed [31:0] w_im2;
    logic               r_p_vld;
    logic [31:0]        r_p;

    logic [4:0]         w_top;
    logic [31:0]        w_norm;

    // Index 0 is the normalisation stage, 1..N the squaring stages.
    logic [31:0]                       r_y    [N+1];
    logic [sbc_pkg::FRAC_W-1:0]        r_frac [N+1];
    logic [sbc_pkg::INT_W-1:0]         r_int  [N+1];
    logic                              r_zero [N+1];
    logic                              r_vld  [N+1];

    assign w_re2 = i_re * i_re;
    assign w_im2 = i_im * i_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_ce) begin
            r_p_vld <= i_vld;
        end
        if (i_ce) begin
            r_p <= $unsigned(w_re2) + $unsigned(w_im2);
        end
    end

    // Leading-one position of the power.
    always_comb begin
        w_top = '0;
        for (int b = 0; b < 32; b++) begin
            if (r_p[b]) begin
                w_top = 5'(b);
            end
        end
        w_norm = r_p << (5'd31 - w_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= r_p_vld;
        end
        if (i_ce) begin
            r_y[0]    <= w_norm;
            r_int[0]  <= w_top;
            r_frac[0] <= '0;
            r_zero[0] <= (r_p == 32'd0);
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_sq
        // Fraction bit decided by this stage.
        localparam logic [sbc_pkg::FRAC_W-1:0] F_BIT = sbc_pkg::FRAC_W'(1 << (N - k));

        logic [63:0] w_sq;
        logic [32:0] w_t;

        assign w_sq = 64'(r_y[k-1]) * 64'(r_y[k-1]);
        assign w_t  = w_sq[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (i_ce) begin
                r_int[k]  <= r_int[k-1];
                r_zero[k] <= r_zero[k-1];
                if (w_t[32]) begin
                    r_y[k]    <= w_t[32:1];
                    r_frac[k] <= r_frac[k-1] | F_BIT;
                end else begin
                    r_y[k]    <= w_t[31:0];
                    r_frac[k] <= r_frac[k-1];
                end
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_log  = {r_int[N], r_frac[N]};
    assign o_zero = r_zero[N];

endmodule

// ----- rtl/sbc_scale.sv -----
// Decibel scaling and range classification: level product, comparison
// against the range registers and forming of the divider operands. Uses sbc_pkg.
module sbc_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_ce,
    input  logic                              i_vld,
    input  logic [sbc_pkg::LOG_W-1:0]         i_log,
    input  logic                              i_zero,
    input  logic signed [sbc_pkg::DB_W-1:0]   i_min_db,
    input  logic signed [sbc_pkg::DB_W-1:0]   i_max_db,
    output logic                              o_vld,
    output logic [sbc_pkg::DIVD_W-1:0]        o_dividend,
    output logic [sbc_pkg::DSR_W-1:0]         o_divisor,
    output sbc_pkg::t_cls                     o_cls
);

    logic signed [21:0] w_diff;
    logic signed [49:0] w_num;
    logic signed [49:0] w_den;
    logic signed [8:0]  w_range;
    sbc_pkg::t_cls      w_cls;

    logic               r_e_vld;
    logic               r_e_zero;
    logic signed [48:0] r_e_level;

    logic               r_f_vld;
    sbc_pkg::t_cls      r_f_cls;
    logic [sbc_pkg::NUM_W-1:0] r_f_num;
    logic [7:0]         r_f_range;

    logic               r_g_vld;
    sbc_pkg::t_cls      r_g_cls;
    logic [sbc_pkg::DIVD_W-1:0] r_g_dividend;
    logic [sbc_pkg::DSR_W-1:0]  r_g_divisor;

    assign w_diff = $signed({1'b0, i_log}) - sbc_pkg::LOG_OFFSET;

    // Level in Q.40: log difference (Q.16) times 10*log10(2) (Q.24).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_ce) begin
            r_e_vld <= i_vld;
        end
        if (i_ce) begin
            r_e_zero  <= i_zero;
            r_e_level <= 49'(w_diff) * 49'(sbc_pkg::TEN_LOG10_2_Q24);
        end
    end

    assign w_range = 9'(i_max_db) - 9'(i_min_db);
    assign w_num   = 50'(r_e_level) - (50'(i_min_db) <<< 40);
    assign w_den   = 50'(w_range) <<< 40;

    always_comb begin
        if (r_e_zero) begin
            w_cls = '{force_low: 1'b1, force_high: 1'b0};
        end else if (w_den <= 0) begin
            // Empty range: everything at or above the lower bound is on top.
            w_cls = '{force_low: (w_num < 0), force_high: (w_num >= 0)};
        end else begin
            w_cls = '{force_low: (w_num <= 0), force_high: (w_num >= w_den)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (i_ce) begin
            r_f_vld <= r_e_vld;
        end
        if (i_ce) begin
            r_f_cls   <= w_cls;
            r_f_num   <= w_num[sbc_pkg::NUM_W-1:0];
            r_f_range <= w_range[7:0];
        end
    end

    // Round half up: dividend 2*num*1023 + den, divisor 2*den.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (i_ce) begin
            r_g_vld <= r_f_vld;
        end
        if (i_ce) begin
            r_g_cls      <= r_f_cls;
            r_g_dividend <= (60'(r_f_num) << 11) - (60'(r_f_num) << 1)
                            + (60'(r_f_range) << 40);
            r_g_divisor  <= 49'(r_f_range) << 41;
        end
    end

    assign o_vld      = r_g_vld;
    assign o_dividend = r_g_dividend;
    assign o_divisor  = r_g_divisor;
    assign o_cls      = r_g_cls;

endmodule

// ----- rtl/sbc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with the final
// index selection. Uses sbc_pkg.
module sbc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_vld,
    input  logic [sbc_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [sbc_pkg::DSR_W-1:0]     i_divisor,
    input  sbc_pkg::t_cls                 i_cls,
    output logic                          o_vld,
    output logic [sbc_pkg::IDX_W-1:0]     o_idx
);

    localparam int N = sbc_pkg::DIV_STAGES;

    logic [sbc_pkg::DIVD_W-1:0] s_rem [N+1];
    logic [sbc_pkg::DSR_W-1:0]  s_dsr [N+1];
    logic [sbc_pkg::IDX_W-1:0]  s_q   [N+1];
    sbc_pkg::t_cls              s_cls [N+1];
    logic                       s_vld [N+1];

    assign s_rem[0] = i_dividend;
    assign s_dsr[0] = i_divisor;
    assign s_q[0]   = '0;
    assign s_cls[0] = i_cls;
    assign s_vld[0] = i_vld;

    for (genvar k = 1; k <= N; k++) begin : g_stage
        localparam int B = N - k;
        // Quotient bit decided by this stage.
        localparam logic [sbc_pkg::IDX_W-1:0] Q_BIT = sbc_pkg::IDX_W'(1 << B);

        logic [sbc_pkg::DIVD_W-1:0] w_sub;

        assign w_sub = sbc_pkg::DIVD_W'(s_dsr[k-1]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_vld[k] <= 1'b0;
            end else if (i_ce) begin
                s_vld[k] <= s_vld[k-1];
            end
            if (i_ce) begin
                s_dsr[k] <= s_dsr[k-1];
                s_cls[k] <= s_cls[k-1];
                if (s_rem[k-1] >= w_sub) begin
                    s_rem[k] <= s_rem[k-1] - w_sub;
                    s_q[k]   <= s_q[k-1] | Q_BIT;
                end else begin
                    s_rem[k] <= s_rem[k-1];
                    s_q[k]   <= s_q[k-1];
                end
            end
        end
    end

    always_comb begin
        if (s_cls[N].force_low) begin
            o_idx = '0;
        end else if (s_cls[N].force_high) begin
            o_idx = sbc_pkg::LUT_TOP;
        end else begin
            o_idx = s_q[N];
        end
    end

    assign o_vld = s_vld[N];

endmodule

// ----- rtl/spectrum_bin_to_colormap_top.sv -----
// Top level of the spectrum bin to jet colour pipeline.
// Instantiates sbc_log2, sbc_scale and sbc_div; uses sbc_pkg.
//
// Usage:
//   Slave channel s_axis_*: one beat per FFT bin, tdata = {imag_part, real_part}.
//   Master channel m_axis_*: one beat per bin, tdata = RGB565 jet colour.
//   Configuration: i_cfg_we writes i_cfg_data into min_db (index 0) or
//   max_db (index 1) on the rising edge; write only while the pipeline is
//   empty.
// Each bin's power is formed exactly, its base-2 logarithm is taken in fixed
// point by sixteen squaring stages, scaled to decibels, normalised between
// min_db and max_db by a ten-stage restoring divider and looked up in the
// constant 1024-entry colour table.
// Throughput is one beat per cycle when the receiver does not stall, set by
// the fully pipelined squaring and divider stages.
// All stages advance together whenever the output register is empty or is
// being taken; while the receiver holds m_axis_tready low with a result
// waiting, the whole pipeline holds and s_axis_tready is low.
// Reset clears every valid bit and loads min_db = -50 dB, max_db = 50 dB.
module spectrum_bin_to_colormap_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] real_part, [31:16] imag_part
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pixel_color
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    logic                               w_ce;
    logic signed [sbc_pkg::DB_W-1:0]    r_min_db;
    logic signed [sbc_pkg::DB_W-1:0]    r_max_db;

    logic                               w_log_vld;
    logic [sbc_pkg::LOG_W-1:0]          w_log;
    logic                               w_log_zero;

    logic                               w_sc_vld;
    logic [sbc_pkg::DIVD_W-1:0]         w_dividend;
    logic [sbc_pkg::DSR_W-1:0]          w_divisor;
    sbc_pkg::t_cls                      w_cls;

    logic                               w_idx_vld;
    logic [sbc_pkg::IDX_W-1:0]          w_idx;

    logic                               r_out_vld;
    logic [15:0]                        r_out_data;

    // One enable for every stage: move when the output slot is free or leaving.
    assign w_ce          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_db <= sbc_pkg::MIN_DB_RST;
            r_max_db <= sbc_pkg::MAX_DB_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbc_pkg::CFG_MIN_DB: r_min_db <= i_cfg_data;
                sbc_pkg::CFG_MAX_DB: r_max_db <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sbc_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (s_axis_tvalid),
        .i_re    (s_axis_tdata[15:0]),
        .i_im    (s_axis_tdata[31:16]),
        .o_vld   (w_log_vld),
        .o_log   (w_log),
        .o_zero  (w_log_zero)
    );

    sbc_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (w_ce),
        .i_vld      (w_log_vld),
        .i_log      (w_log),
        .i_zero     (w_log_zero),
        .i_min_db   (r_min_db),
        .i_max_db   (r_max_db),
        .o_vld      (w_sc_vld),
        .o_dividend (w_dividend),
        .o_divisor  (w_divisor),
        .o_cls      (w_cls)
    );

    sbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (w_ce),
        .i_vld      (w_sc_vld),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_cls      (w_cls),
        .o_vld      (w_idx_vld),
        .o_idx      (w_idx)
    );

    // The index maps one to one onto the table, so the table read is the
    // output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= w_idx_vld;
        end
        if (w_ce) begin
            r_out_data <= sbc_pkg::JET565[w_idx];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/sbc_checker.sv -----
// Port-level checker for the spectrum bin to colour pipeline, bound to the
// top level. Depends only on the top-level ports.
module sbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A waiting result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // The input side is stalled exactly when a result waits untaken.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the output stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind spectrum_bin_to_colormap_top sbc_checker u_sbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
